// File: design/ssq_pkg.sv
// Shared types and constants of the stable sorted priority queue.
package ssq_pkg;

  localparam int DEPTH_DEF       = 512;
  localparam int WEIGHT_BITS_DEF = 32;
  localparam int SYMBOL_BITS     = 8;
  localparam int NODE_BITS       = 9;
  localparam int STATUS_BITS     = 2;

  // Request opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } cell_ctrl_t;

endpackage

// File: design/stable_sorted_priority_queue_core.sv
// Top level of the stable sorted priority queue: cell chain, count and result register.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  request | req_valid, req_stall | opcode, weight, symbol, node_ref
//  result  | rsp_valid, rsp_stall | status, out_weight, out_symbol, out_node_ref,
//          |                      | is_empty, has_one
//
// One request per cycle while no waiting result is stalled: every cell compares
// the new entry with its own in the same cycle and the whole chain shifts at once,
// so an insert or a removal completes as it is accepted. The result is registered
// and appears in the cycle after acceptance. Reset clears the entry count and the
// result valid; entry storage is not cleared, no clearing pass. A stalled result
// holds the request side only while it is still waiting to be taken.
module stable_sorted_priority_queue_core #(
  parameter int DEPTH       = ssq_pkg::DEPTH_DEF,
  parameter int WEIGHT_BITS = ssq_pkg::WEIGHT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             opcode,
  input  logic [WEIGHT_BITS-1:0]           weight,
  input  logic [ssq_pkg::SYMBOL_BITS-1:0]  symbol,
  input  logic [ssq_pkg::NODE_BITS-1:0]    node_ref,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [ssq_pkg::STATUS_BITS-1:0]  status,
  output logic [WEIGHT_BITS-1:0]           out_weight,
  output logic [ssq_pkg::SYMBOL_BITS-1:0]  out_symbol,
  output logic [ssq_pkg::NODE_BITS-1:0]    out_node_ref,
  output logic                             is_empty,
  output logic                             has_one
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         accept;
  logic                         ins_ok;
  logic                         del_ok;
  ssq_pkg::cell_ctrl_t          ctrl;

  logic [DEPTH-1:0]             after;
  logic [WEIGHT_BITS-1:0]       c_weight   [DEPTH];
  logic [ssq_pkg::SYMBOL_BITS-1:0] c_symbol [DEPTH];
  logic [ssq_pkg::NODE_BITS-1:0]   c_node   [DEPTH];

  // Accept a request unless a finished result is still waiting
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign ins_ok    = accept && (opcode == ssq_pkg::OP_ENQ) && (count != CNT_W'(DEPTH));
  assign del_ok    = accept && (opcode == ssq_pkg::OP_DEQ) && (count != '0);
  assign ctrl.ins  = ins_ok;
  assign ctrl.del  = del_ok;

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // Build the chain; cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                            l_after;
    logic [WEIGHT_BITS-1:0]          l_weight;
    logic [ssq_pkg::SYMBOL_BITS-1:0] l_symbol;
    logic [ssq_pkg::NODE_BITS-1:0]   l_node;
    logic [WEIGHT_BITS-1:0]          r_weight;
    logic [ssq_pkg::SYMBOL_BITS-1:0] r_symbol;
    logic [ssq_pkg::NODE_BITS-1:0]   r_node;

    if (i == 0) begin : g_head
      assign l_after  = 1'b0;
      assign l_weight = weight;
      assign l_symbol = symbol;
      assign l_node   = node_ref;
    end else begin : g_mid
      assign l_after  = after[i-1];
      assign l_weight = c_weight[i-1];
      assign l_symbol = c_symbol[i-1];
      assign l_node   = c_node[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_weight = c_weight[i];
      assign r_symbol = c_symbol[i];
      assign r_node   = c_node[i];
    end else begin : g_body
      assign r_weight = c_weight[i+1];
      assign r_symbol = c_symbol[i+1];
      assign r_node   = c_node[i+1];
    end

    ssq_cell #(
      .WEIGHT_BITS(WEIGHT_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .occupied      (count > CNT_W'(i)),
      .new_weight    (weight),
      .new_symbol    (symbol),
      .new_node_ref  (node_ref),
      .left_after    (l_after),
      .left_weight   (l_weight),
      .left_symbol   (l_symbol),
      .left_node_ref (l_node),
      .right_weight  (r_weight),
      .right_symbol  (r_symbol),
      .right_node_ref(r_node),
      .after         (after[i]),
      .weight        (c_weight[i]),
      .symbol        (c_symbol[i]),
      .node_ref      (c_node[i])
    );
  end

  // Hold the entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Advance the result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Capture the result payload on each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      is_empty <= (count_next == '0);
      has_one  <= (count_next == CNT_W'(1));
      if (del_ok) begin
        status       <= ssq_pkg::ST_DONE;
        out_weight   <= c_weight[0];
        out_symbol   <= c_symbol[0];
        out_node_ref <= c_node[0];
      end else begin
        out_weight   <= '0;
        out_symbol   <= '0;
        out_node_ref <= '0;
        if (opcode == ssq_pkg::OP_DEQ) begin
          status <= ssq_pkg::ST_EMPTY;
        end else if (ins_ok) begin
          status <= ssq_pkg::ST_DONE;
        end else begin
          status <= ssq_pkg::ST_FULL;
        end
      end
    end
  end

endmodule

// File: design/ssq_cell.sv
// One cell of the sorted chain: holds one entry and shifts with its neighbors.
module ssq_cell #(
  parameter int WEIGHT_BITS = ssq_pkg::WEIGHT_BITS_DEF
) (
  input  logic                         clk,
  input  ssq_pkg::cell_ctrl_t          ctrl,
  input  logic                         occupied,
  input  logic [WEIGHT_BITS-1:0]       new_weight,
  input  logic [ssq_pkg::SYMBOL_BITS-1:0] new_symbol,
  input  logic [ssq_pkg::NODE_BITS-1:0]   new_node_ref,
  input  logic                         left_after,
  input  logic [WEIGHT_BITS-1:0]       left_weight,
  input  logic [ssq_pkg::SYMBOL_BITS-1:0] left_symbol,
  input  logic [ssq_pkg::NODE_BITS-1:0]   left_node_ref,
  input  logic [WEIGHT_BITS-1:0]       right_weight,
  input  logic [ssq_pkg::SYMBOL_BITS-1:0] right_symbol,
  input  logic [ssq_pkg::NODE_BITS-1:0]   right_node_ref,
  output logic                         after,
  output logic [WEIGHT_BITS-1:0]       weight,
  output logic [ssq_pkg::SYMBOL_BITS-1:0] symbol,
  output logic [ssq_pkg::NODE_BITS-1:0]   node_ref
);

  logic new_first;

  // New entry goes at or before this cell when the cell is free or strictly follows it
  assign new_first = (new_weight < weight) ||
                     ((new_weight == weight) && (new_symbol < symbol));
  assign after     = !occupied || new_first;

  // Insert: take the new entry at the boundary, shift right past it; remove: shift left
  always_ff @(posedge clk) begin
    if (ctrl.ins && after) begin
      if (left_after) begin
        weight   <= left_weight;
        symbol   <= left_symbol;
        node_ref <= left_node_ref;
      end else begin
        weight   <= new_weight;
        symbol   <= new_symbol;
        node_ref <= new_node_ref;
      end
    end else if (ctrl.del) begin
      weight   <= right_weight;
      symbol   <= right_symbol;
      node_ref <= right_node_ref;
    end
  end

endmodule
